// ===== hw/rtl/slt_pkg.sv =====
// Shared types and codes for the sorted list table.
// Used by the controller, the datapath, the top level and the checker.
package slt_pkg;

  localparam int POS_W = 6;
  localparam int PORT_VALUE_W = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EMPTY     = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_FIND,
    ST_APPLY,
    ST_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic  capture;
    logic  compare;
    logic  find;
    logic  insert;
    logic  remove;
    logic  rotate;
    logic  rd_clear;
    logic  rd_step;
    logic  emit;
    stat_t stat;
    logic  sel_entry;
    logic  zero_val;
    logic  zero_pos;
    logic  last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  found;
    logic  out_free;
    logic  rd_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/slt_ctrl.sv =====
// Controller state machine of the sorted list table.
// Depends on slt_pkg for the state, mode and command types.
module slt_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  slt_pkg::dp_status_t st,
  output slt_pkg::dp_cmd_t    cmd
);
  import slt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CMP;
      end
      ST_CMP:  state_next = ST_FIND;
      ST_FIND: state_next = ST_APPLY;
      ST_APPLY: begin
        if (st.out_free) begin
          if (st.mode == MODE_READ && !st.empty) state_next = ST_READ;
          else state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (st.out_free && st.rd_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.stat = STAT_DONE;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.capture = in_valid;
      ST_CMP:  cmd.compare = 1'b1;
      ST_FIND: cmd.find = 1'b1;
      ST_APPLY: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          unique case (st.mode)
            MODE_INSERT, MODE_APPEND: begin
              if (st.full) begin
                cmd.stat     = STAT_FULL;
                cmd.zero_pos = 1'b1;
              end else begin
                cmd.insert = 1'b1;
              end
            end
            MODE_DELETE: begin
              if (st.found) begin
                cmd.remove = 1'b1;
              end else begin
                cmd.stat     = STAT_NOT_FOUND;
                cmd.zero_pos = 1'b1;
              end
            end
            MODE_READ: begin
              if (st.empty) begin
                cmd.stat     = STAT_EMPTY;
                cmd.zero_val = 1'b1;
                cmd.zero_pos = 1'b1;
              end else begin
                // no beat here; the read state sends every entry
                cmd.emit     = 1'b0;
                cmd.rd_clear = 1'b1;
              end
            end
            default: cmd.emit = 1'b0;
          endcase
        end
      end
      ST_READ: begin
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel_entry = 1'b1;
          cmd.rotate    = 1'b1;
          cmd.rd_step   = 1'b1;
          cmd.last      = st.rd_last;
        end
      end
      default: cmd.emit = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/slt_datapath.sv =====
// Datapath of the sorted list table: entry cells, compare flags, position
// search, read counter and output register. Depends on slt_pkg.
module slt_datapath #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [1:0]                             mode,
  input  logic signed [slt_pkg::PORT_VALUE_W-1:0] value,
  input  slt_pkg::dp_cmd_t                       cmd,
  output slt_pkg::dp_status_t                    st,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             status,
  output logic signed [slt_pkg::PORT_VALUE_W-1:0] value_out,
  output logic [slt_pkg::POS_W-1:0]              position,
  output logic                                   last
);
  import slt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic signed [VALUE_WIDTH-1:0] entries [DEPTH];
  logic [CW-1:0]                 count;
  mode_t                         op_mode;
  logic signed [VALUE_WIDTH-1:0] op_value;
  logic [DEPTH-1:0]              le_flag;
  logic [DEPTH-1:0]              eq_flag;
  logic [CW-1:0]                 pos;
  logic                          found;
  logic [IW-1:0]                 rd_idx;
  logic [CW-1:0]                 ins_pos;
  logic [CW-1:0]                 del_pos;
  logic [CW-1:0]                 pos_sel;
  logic [CW+POS_W-1:0]           pos_ext;
  logic                          out_free;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode  <= mode_t'(mode);
      op_value <= VALUE_WIDTH'(value);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CW-1:0] IPOS = CW'(i);
    logic signed [VALUE_WIDTH-1:0] prev_v;
    logic signed [VALUE_WIDTH-1:0] next_v;

    if (i > 0) begin : g_prev
      assign prev_v = entries[i-1];
    end else begin : g_prev_head
      assign prev_v = entries[i];
    end
    if (i < DEPTH - 1) begin : g_next
      assign next_v = entries[i+1];
    end else begin : g_next_tail
      assign next_v = entries[i];
    end

    always_ff @(posedge clk) begin
      if (cmd.compare) begin
        le_flag[i] <= (entries[i] <= op_value) && (IPOS < count);
        eq_flag[i] <= (entries[i] == op_value) && (IPOS < count);
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (IPOS == pos) entries[i] <= op_value;
        else if (IPOS > pos) entries[i] <= prev_v;
      end else if (cmd.remove) begin
        if (IPOS >= pos) entries[i] <= next_v;
      end else if (cmd.rotate) begin
        // rotate the live entries by one so the head always holds the next one
        if (IPOS == count - CW'(1)) entries[i] <= entries[0];
        else if (IPOS < count) entries[i] <= next_v;
      end
    end
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (le_flag[i]) ins_pos = CW'(i + 1);
    end
  end

  always_comb begin
    del_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (eq_flag[i]) del_pos = CW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      found <= |eq_flag;
      unique case (op_mode)
        MODE_INSERT: pos <= ins_pos;
        MODE_APPEND: pos <= count;
        MODE_DELETE: pos <= del_pos;
        MODE_READ:   pos <= '0;
        default:     pos <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      count <= count + CW'(1);
    end else if (cmd.remove) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_clear) rd_idx <= '0;
    else if (cmd.rd_step) rd_idx <= rd_idx + IW'(1);
  end

  assign out_free = !out_valid || !out_stall;
  assign pos_sel  = cmd.zero_pos ? '0 : (cmd.sel_entry ? CW'(rd_idx) : pos);
  assign pos_ext  = {{POS_W{1'b0}}, pos_sel};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status   <= cmd.stat;
      position <= pos_ext[POS_W-1:0];
      last     <= cmd.last;
      if (cmd.zero_val) value_out <= '0;
      else if (cmd.sel_entry) value_out <= PORT_VALUE_W'(entries[0]);
      else value_out <= PORT_VALUE_W'(op_value);
    end
  end

  assign st.mode     = op_mode;
  assign st.full     = (count == CW'(DEPTH));
  assign st.empty    = (count == '0);
  assign st.found    = found;
  assign st.out_free = out_free;
  assign st.rd_last  = (CW'(rd_idx) == count - CW'(1));

endmodule

// ===== hw/rtl/sorted_list_table_core.sv =====
// Top level of the sorted list table: controller plus datapath.
// Depends on slt_pkg, slt_ctrl and slt_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command beat: mode and
//   value. Modes: sorted insert, append at tail, delete first equal, read out.
//   Output channel (out_valid / out_stall) carries result beats: status,
//   value_out, position and last, which marks the final beat of a command.
// Timing:
//   A command is taken only while the controller is idle. It then passes the
//   compare state (parallel compare of all entries), the position search
//   state and the apply state, which shifts the entry cells and loads the
//   output register. An insert, append or delete then returns to idle, where
//   the next command can be taken.
//   A read-out of N entries sends N beats from the read state, one per cycle
//   while the receiver does not stall; the entry cells rotate once per beat
//   and end in their original order.
// Reset clears the entry count (table empty), the controller and the output
// valid. When the receiver stalls, the output register holds its beat and the
// controller waits before the next shift or beat.
module sorted_list_table_core #(
  parameter int DEPTH       = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic signed [slt_pkg::PORT_VALUE_W-1:0] value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             status,
  output logic signed [slt_pkg::PORT_VALUE_W-1:0] value_out,
  output logic [slt_pkg::POS_W-1:0]              position,
  output logic                                   last
);
  import slt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  slt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  slt_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .mode      (mode),
    .value     (value),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .value_out (value_out),
    .position  (position),
    .last      (last)
  );

endmodule

// ===== hw/rtl/slt_checker.sv =====
// Port-level checker for the sorted list table, bound to the top level.
// Depends on slt_pkg for the status codes.
module slt_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic [1:0]                             status,
  input logic signed [slt_pkg::PORT_VALUE_W-1:0] value_out,
  input logic [slt_pkg::POS_W-1:0]              position,
  input logic                                   last
);
  import slt_pkg::*;

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(value_out)
      && $stable(position) && $stable(last))
    else $error("stalled output beat changed");

  // one command at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a command is in progress");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DONE |-> last && position == '0)
    else $error("error beat not final or has a position");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> value_out == '0)
    else $error("empty read-out beat carries a value");

endmodule

bind sorted_list_table_core slt_checker u_slt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .value_out (value_out),
  .position  (position),
  .last      (last)
);
